// ----- src/fbc_pkg.sv -----
`timescale 1ns / 1ps
// Package for the frustum box culler: micro-operation type, operation and phase codes,
// scratch store address map and the sequencer decode function.
// Depends on nothing; used by frustum_box_culler_unit and fbc_alu.
package fbc_pkg;

    // Operation codes of the micro-operations, run on the shared arithmetic unit or the divider.
    localparam logic [2:0] OP_MOV = 3'd0;
    localparam logic [2:0] OP_NEG = 3'd1;
    localparam logic [2:0] OP_ADD = 3'd2;
    localparam logic [2:0] OP_SUB = 3'd3;
    localparam logic [2:0] OP_MUL = 3'd4;
    localparam logic [2:0] OP_DIV = 3'd5;
    localparam logic [2:0] OP_TST = 3'd6;

    // Sequencer phases.
    localparam logic [2:0] PH_COF = 3'd0;
    localparam logic [2:0] PH_DET = 3'd1;
    localparam logic [2:0] PH_INV = 3'd2;
    localparam logic [2:0] PH_CRN = 3'd3;
    localparam logic [2:0] PH_PLN = 3'd4;
    localparam logic [2:0] PH_BOX = 3'd5;

    // Scratch store address map.
    localparam int          AW       = 7;
    localparam int          DEPTH    = 128;
    localparam logic [6:0]  PL_BASE  = 7'd16;
    localparam logic [6:0]  COF_BASE = 7'd40;
    localparam logic [6:0]  INV_BASE = 7'd56;
    localparam logic [6:0]  POS_BASE = 7'd72;
    localparam logic [6:0]  T_BASE   = 7'd96;
    localparam logic [6:0]  DET_ADDR = 7'd101;
    localparam logic [6:0]  H_BASE   = 7'd104;
    localparam logic [6:0]  E1_BASE  = 7'd108;
    localparam logic [6:0]  E2_BASE  = 7'd111;
    localparam logic [6:0]  BOX_LO   = 7'd120;
    localparam logic [6:0]  BOX_HI   = 7'd123;
    localparam logic [3:0]  BOX_TAG  = 4'b1111;
    localparam logic [3:0]  REBUILD_IDX = 4'd15;

    typedef struct packed {
        logic [2:0] op;
        logic [6:0] a;
        logic [6:0] b;
        logic [6:0] dst;
    } t_uop;

    typedef logic [0:4][2:0] t_pdef;

    function automatic t_uop mk(logic [2:0] op, logic [6:0] a, logic [6:0] b, logic [6:0] d);
        t_uop u;
        u.op  = op;
        u.a   = a;
        u.b   = b;
        u.dst = d;
        return u;
    endfunction

    function automatic logic [6:0] tmp(logic [2:0] n);
        return T_BASE + 7'(n);
    endfunction

    function automatic logic [6:0] a_m(logic [1:0] row, logic [1:0] col);
        return {3'b000, col, row};
    endfunction

    function automatic logic [6:0] a_cof(logic [1:0] r, logic [1:0] c);
        return COF_BASE + 7'({r, c});
    endfunction

    function automatic logic [6:0] a_inv(logic [1:0] r, logic [1:0] c);
        return INV_BASE + 7'({r, c});
    endfunction

    function automatic logic [6:0] a_pos(logic [2:0] k, logic [1:0] n);
        return POS_BASE + 7'(k) * 7'd3 + 7'(n);
    endfunction

    function automatic logic [6:0] a_pl(logic [2:0] p, logic [1:0] n);
        return PL_BASE + 7'({p, n});
    endfunction

    // Element n of the 3x3 minor that drops row r and column c.
    function automatic logic [6:0] a_mnr(logic [1:0] r, logic [1:0] c, logic [3:0] n);
        logic [1:0] mi;
        logic [1:0] mj;
        logic [1:0] ri;
        logic [1:0] cj;
        case (n)
            4'd0, 4'd1, 4'd2: mi = 2'd0;
            4'd3, 4'd4, 4'd5: mi = 2'd1;
            default:          mi = 2'd2;
        endcase
        case (n)
            4'd0, 4'd3, 4'd6: mj = 2'd0;
            4'd1, 4'd4, 4'd7: mj = 2'd1;
            default:          mj = 2'd2;
        endcase
        ri = (mi >= r) ? mi + 2'd1 : mi;
        cj = (mj >= c) ? mj + 2'd1 : mj;
        return a_m(ri, cj);
    endfunction

    // Clip-cube corner signs as {x, y, z}, a set bit meaning +1.
    function automatic logic [2:0] clip_sign(logic [2:0] k);
        case (k)
            3'd0:    return 3'b000;
            3'd1:    return 3'b010;
            3'd2:    return 3'b001;
            3'd3:    return 3'b100;
            3'd4:    return 3'b110;
            3'd5:    return 3'b101;
            default: return 3'b111;
        endcase
    endfunction

    // Per plane: edge one tip and base, edge two tip and base, point on the plane.
    function automatic t_pdef plane_def(logic [2:0] p);
        case (p)
            3'd0:    return {3'd1, 3'd0, 3'd3, 3'd0, 3'd0};
            3'd1:    return {3'd6, 3'd5, 3'd2, 3'd5, 3'd2};
            3'd2:    return {3'd2, 3'd0, 3'd1, 3'd0, 3'd0};
            3'd3:    return {3'd4, 3'd3, 3'd5, 3'd3, 3'd3};
            3'd4:    return {3'd1, 3'd4, 3'd6, 3'd4, 3'd1};
            default: return {3'd5, 3'd3, 3'd0, 3'd3, 3'd0};
        endcase
    endfunction

    function automatic logic [4:0] step_last(logic [2:0] ph);
        case (ph)
            PH_COF:  return 5'd14;
            PH_DET:  return 5'd7;
            PH_INV:  return 5'd15;
            PH_CRN:  return 5'd18;
            PH_PLN:  return 5'd20;
            default: return 5'd5;
        endcase
    endfunction

    function automatic logic [5:0] iter_last(logic [2:0] ph);
        case (ph)
            PH_COF:  return 6'd15;
            PH_DET:  return 6'd0;
            PH_INV:  return 6'd0;
            PH_CRN:  return 6'd6;
            PH_PLN:  return 6'd5;
            default: return 6'd47;
        endcase
    endfunction

    // Decode of the micro-operation for a phase, an iteration and a step.
    function automatic t_uop uop_of(logic [2:0] ph, logic [5:0] it, logic [4:0] s);
        logic [1:0] r;
        logic [1:0] c;
        logic [1:0] n;
        logic [2:0] k;
        logic [2:0] sg;
        logic [2:0] p;
        logic [2:0] cn;
        t_pdef      pd;
        t_uop       u;
        r  = it[3:2];
        c  = it[1:0];
        k  = it[2:0];
        sg = clip_sign(it[2:0]);
        p  = it[2:0];
        cn = it[2:0];
        pd = plane_def(it[2:0]);
        u  = mk(OP_MOV, T_BASE, T_BASE, T_BASE);
        case (ph)
            PH_COF: begin
                case (s)
                    5'd0:  u = mk(OP_MUL, a_mnr(r, c, 4'd4), a_mnr(r, c, 4'd8), tmp(3'd0));
                    5'd1:  u = mk(OP_MUL, a_mnr(r, c, 4'd5), a_mnr(r, c, 4'd7), tmp(3'd1));
                    5'd2:  u = mk(OP_SUB, tmp(3'd0), tmp(3'd1), tmp(3'd0));
                    5'd3:  u = mk(OP_MUL, a_mnr(r, c, 4'd0), tmp(3'd0), tmp(3'd2));
                    5'd4:  u = mk(OP_MUL, a_mnr(r, c, 4'd3), a_mnr(r, c, 4'd8), tmp(3'd0));
                    5'd5:  u = mk(OP_MUL, a_mnr(r, c, 4'd5), a_mnr(r, c, 4'd6), tmp(3'd1));
                    5'd6:  u = mk(OP_SUB, tmp(3'd0), tmp(3'd1), tmp(3'd0));
                    5'd7:  u = mk(OP_MUL, a_mnr(r, c, 4'd1), tmp(3'd0), tmp(3'd3));
                    5'd8:  u = mk(OP_MUL, a_mnr(r, c, 4'd3), a_mnr(r, c, 4'd7), tmp(3'd0));
                    5'd9:  u = mk(OP_MUL, a_mnr(r, c, 4'd4), a_mnr(r, c, 4'd6), tmp(3'd1));
                    5'd10: u = mk(OP_SUB, tmp(3'd0), tmp(3'd1), tmp(3'd0));
                    5'd11: u = mk(OP_MUL, a_mnr(r, c, 4'd2), tmp(3'd0), tmp(3'd4));
                    5'd12: u = mk(OP_SUB, tmp(3'd2), tmp(3'd3), tmp(3'd2));
                    5'd13: u = mk(OP_ADD, tmp(3'd2), tmp(3'd4), tmp(3'd2));
                    default: begin
                        u = mk((r[0] ^ c[0]) ? OP_NEG : OP_MOV, tmp(3'd2), tmp(3'd2),
                               a_cof(r, c));
                    end
                endcase
            end
            PH_DET: begin
                n = s[2:1];
                if (!s[0]) begin
                    u = mk(OP_MUL, a_m(2'd0, n), a_cof(2'd0, n), tmp(3'd0));
                end else if (n == 2'd0) begin
                    u = mk(OP_MOV, tmp(3'd0), tmp(3'd0), DET_ADDR);
                end else begin
                    u = mk(OP_ADD, DET_ADDR, tmp(3'd0), DET_ADDR);
                end
            end
            PH_INV: begin
                u = mk(OP_DIV, a_cof(s[1:0], s[3:2]), DET_ADDR, a_inv(s[3:2], s[1:0]));
            end
            PH_CRN: begin
                if (!s[4]) begin
                    n = s[3:2];
                    case (s[1:0])
                        2'd0: u = mk(sg[2] ? OP_MOV : OP_NEG, a_inv(n, 2'd0), a_inv(n, 2'd0),
                                     tmp(3'd0));
                        2'd1: u = mk(sg[1] ? OP_ADD : OP_SUB, tmp(3'd0), a_inv(n, 2'd1),
                                     tmp(3'd0));
                        2'd2: u = mk(sg[0] ? OP_ADD : OP_SUB, tmp(3'd0), a_inv(n, 2'd2),
                                     tmp(3'd0));
                        default: u = mk(OP_ADD, tmp(3'd0), a_inv(n, 2'd3), H_BASE + 7'(n));
                    endcase
                end else begin
                    n = s[1:0];
                    u = mk(OP_DIV, H_BASE + 7'(n), H_BASE + 7'd3, a_pos(k, n));
                end
            end
            PH_PLN: begin
                case (s)
                    5'd0, 5'd1, 5'd2: begin
                        n = s[1:0];
                        u = mk(OP_SUB, a_pos(pd[0], n), a_pos(pd[1], n), E1_BASE + 7'(n));
                    end
                    5'd3, 5'd4, 5'd5: begin
                        n = 2'(s - 5'd3);
                        u = mk(OP_SUB, a_pos(pd[2], n), a_pos(pd[3], n), E2_BASE + 7'(n));
                    end
                    5'd6:  u = mk(OP_MUL, E1_BASE + 7'd1, E2_BASE + 7'd2, tmp(3'd0));
                    5'd7:  u = mk(OP_MUL, E1_BASE + 7'd2, E2_BASE + 7'd1, tmp(3'd1));
                    5'd8:  u = mk(OP_SUB, tmp(3'd0), tmp(3'd1), a_pl(p, 2'd0));
                    5'd9:  u = mk(OP_MUL, E1_BASE + 7'd2, E2_BASE, tmp(3'd0));
                    5'd10: u = mk(OP_MUL, E1_BASE, E2_BASE + 7'd2, tmp(3'd1));
                    5'd11: u = mk(OP_SUB, tmp(3'd0), tmp(3'd1), a_pl(p, 2'd1));
                    5'd12: u = mk(OP_MUL, E1_BASE, E2_BASE + 7'd1, tmp(3'd0));
                    5'd13: u = mk(OP_MUL, E1_BASE + 7'd1, E2_BASE, tmp(3'd1));
                    5'd14: u = mk(OP_SUB, tmp(3'd0), tmp(3'd1), a_pl(p, 2'd2));
                    5'd15: u = mk(OP_MUL, a_pl(p, 2'd0), a_pos(pd[4], 2'd0), tmp(3'd0));
                    5'd16: u = mk(OP_MUL, a_pl(p, 2'd1), a_pos(pd[4], 2'd1), tmp(3'd1));
                    5'd17: u = mk(OP_ADD, tmp(3'd0), tmp(3'd1), tmp(3'd0));
                    5'd18: u = mk(OP_MUL, a_pl(p, 2'd2), a_pos(pd[4], 2'd2), tmp(3'd1));
                    5'd19: u = mk(OP_ADD, tmp(3'd0), tmp(3'd1), tmp(3'd0));
                    default: u = mk(OP_NEG, tmp(3'd0), tmp(3'd0), a_pl(p, 2'd3));
                endcase
            end
            PH_BOX: begin
                p = it[5:3];
                case (s)
                    5'd0: u = mk(OP_MUL, cn[2] ? BOX_HI : BOX_LO, a_pl(p, 2'd0), tmp(3'd0));
                    5'd1: u = mk(OP_MUL, (cn[1] ? BOX_HI : BOX_LO) + 7'd1, a_pl(p, 2'd1),
                                 tmp(3'd1));
                    5'd2: u = mk(OP_ADD, tmp(3'd0), tmp(3'd1), tmp(3'd0));
                    5'd3: u = mk(OP_MUL, (cn[0] ? BOX_HI : BOX_LO) + 7'd2, a_pl(p, 2'd2),
                                 tmp(3'd1));
                    5'd4: u = mk(OP_ADD, tmp(3'd0), tmp(3'd1), tmp(3'd0));
                    default: u = mk(OP_TST, tmp(3'd0), a_pl(p, 2'd3), tmp(3'd0));
                endcase
            end
            default: u = mk(OP_MOV, T_BASE, T_BASE, T_BASE);
        endcase
        return u;
    endfunction

endpackage

// ----- src/frustum_box_culler_unit.sv -----
`timescale 1ns / 1ps
// A matrix load of elements 0 to 14 is written while idle and leaves the block idle. Loading
// element 15 rebuilds the planes in 523 micro-operations, 37 of them divides run on the
// iterative divider. A box test runs 288 micro-operations; o_valid rises as the block returns
// to idle, so the next beat can be taken in the cycle in which o_valid rises.
// Reset is synchronous: it clears the sequencer, the output valid and every scratch valid bit, so
// the matrix and planes read as zero and every box is culled until the first rebuild.
module frustum_box_culler_unit #(
    parameter int VALUE_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_operation,
    input  logic [3:0]         i_element_index,
    input  logic signed [31:0] i_element_value,
    input  logic signed [31:0] i_box_min_x,
    input  logic signed [31:0] i_box_min_y,
    input  logic signed [31:0] i_box_min_z,
    input  logic signed [31:0] i_box_max_x,
    input  logic signed [31:0] i_box_max_y,
    input  logic signed [31:0] i_box_max_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_visible
);

    localparam int W = VALUE_BITS;

    // Sequencer states. Each micro-operation reads its operands, executes, then writes back.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_EX   = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_WR   = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]   r_state, n_state;
    logic [2:0]   r_phase, n_phase;
    logic [5:0]   r_it, n_it;
    logic [4:0]   r_s, n_s;
    logic         r_vis, n_vis;
    logic         r_inside, n_inside;
    logic         r_ovalid, n_ovalid;
    logic         r_vis_out, n_vis_out;

    // Scratch store: matrix, planes and every intermediate of the rebuild and the box test.
    logic [W-1:0] r_mem [fbc_pkg::DEPTH];
    logic [fbc_pkg::DEPTH-1:0] r_vld;
    logic [W-1:0] r_box [6];
    logic [W-1:0] r_rda;
    logic [W-1:0] r_rdb;
    logic [W-1:0] r_res;

    fbc_pkg::t_uop uop;
    logic         accept;
    logic         we;
    logic [6:0]   wa;
    logic [W-1:0] wd;
    logic [W-1:0] alu_y;
    logic         div_start;
    logic         div_done;
    logic [W-1:0] div_q;
    logic         res_pos;
    logic         last_s;
    logic         last_it;

    // Saturates a 32-bit input value into the working width.
    function automatic logic [W-1:0] sat_in(logic signed [31:0] x);
        logic signed [64:0] v;
        logic signed [64:0] hi;
        logic signed [64:0] lo;
        v  = 65'(x);
        hi = (65'sd1 <<< (W - 1)) - 65'sd1;
        lo = -hi - 65'sd1;
        if (v > hi) begin
            return hi[W-1:0];
        end else if (v < lo) begin
            return lo[W-1:0];
        end
        return v[W-1:0];
    endfunction

    assign uop       = fbc_pkg::uop_of(r_phase, r_it, r_s);
    assign o_stall   = (r_state != ST_IDLE);
    assign accept    = i_valid && (r_state == ST_IDLE);
    assign div_start = (r_state == ST_EX) && (uop.op == fbc_pkg::OP_DIV);
    assign res_pos   = !r_res[W-1] && (r_res != '0);
    assign last_s    = (r_s == fbc_pkg::step_last(r_phase));
    assign last_it   = (r_it == fbc_pkg::iter_last(r_phase));

    fbc_alu #(.W(W)) u_alu (
        .i_op (uop.op),
        .i_a  (r_rda),
        .i_b  (r_rdb),
        .o_y  (alu_y)
    );

    fbc_div #(.W(W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_a     (r_rda),
        .i_b     (r_rdb),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    // The single write port serves matrix loads in idle and write-back of each result but a test's.
    always_comb begin
        we = 1'b0;
        wa = uop.dst;
        wd = r_res;
        if (accept && !i_operation) begin
            we = 1'b1;
            wa = {3'b000, i_element_index};
            wd = sat_in(i_element_value);
        end else if ((r_state == ST_WR) && (uop.op != fbc_pkg::OP_TST)) begin
            we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (we) begin
            r_vld[wa] <= 1'b1;
        end
    end

    // Operand reads. An entry never written reads as zero; the box corners sit at the top.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_RD) begin
            if (uop.a[6:3] == fbc_pkg::BOX_TAG) begin
                r_rda <= r_box[uop.a[2:0]];
            end else begin
                r_rda <= r_vld[uop.a] ? r_mem[uop.a] : '0;
            end
            r_rdb <= r_vld[uop.b] ? r_mem[uop.b] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_operation) begin
            r_box[0] <= sat_in(i_box_min_x);
            r_box[1] <= sat_in(i_box_min_y);
            r_box[2] <= sat_in(i_box_min_z);
            r_box[3] <= sat_in(i_box_max_x);
            r_box[4] <= sat_in(i_box_max_y);
            r_box[5] <= sat_in(i_box_max_z);
        end
        if (r_state == ST_EX) begin
            r_res <= alu_y;
        end else if ((r_state == ST_DIV) && div_done) begin
            r_res <= div_q;
        end
    end

    // Sequencer: steps walk a phase's micro-operations, iterations walk cofactors, corners,
    // planes or plane-corner pairs, and phases chain through the rebuild.
    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_it      = r_it;
        n_s       = r_s;
        n_vis     = r_vis;
        n_inside  = r_inside;
        n_vis_out = r_vis_out;
        n_ovalid  = r_ovalid && i_stall;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_it = '0;
                    n_s  = '0;
                    if (i_operation) begin
                        n_phase  = fbc_pkg::PH_BOX;
                        n_vis    = 1'b1;
                        n_inside = 1'b0;
                        n_state  = ST_RD;
                    end else if (i_element_index == fbc_pkg::REBUILD_IDX) begin
                        n_phase = fbc_pkg::PH_COF;
                        n_state = ST_RD;
                    end
                end
            end
            ST_RD: begin
                n_state = ST_EX;
            end
            ST_EX: begin
                n_state = (uop.op == fbc_pkg::OP_DIV) ? ST_DIV : ST_WR;
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_WR;
                end
            end
            ST_WR: begin
                // A plane culls when none of its eight corners lies strictly in front of it.
                if (uop.op == fbc_pkg::OP_TST) begin
                    if (r_it[2:0] == 3'd7) begin
                        n_vis    = r_vis && (r_inside || res_pos);
                        n_inside = 1'b0;
                    end else begin
                        n_inside = r_inside || res_pos;
                    end
                end
                n_state = ST_RD;
                if (!last_s) begin
                    n_s = r_s + 5'd1;
                end else begin
                    n_s = '0;
                    if (!last_it) begin
                        n_it = r_it + 6'd1;
                    end else begin
                        n_it = '0;
                        case (r_phase)
                            fbc_pkg::PH_COF: n_phase = fbc_pkg::PH_DET;
                            fbc_pkg::PH_DET: n_phase = fbc_pkg::PH_INV;
                            fbc_pkg::PH_INV: n_phase = fbc_pkg::PH_CRN;
                            fbc_pkg::PH_CRN: n_phase = fbc_pkg::PH_PLN;
                            fbc_pkg::PH_PLN: n_state = ST_IDLE;
                            default:         n_state = ST_OUT;
                        endcase
                    end
                end
            end
            ST_OUT: begin
                // The result waits here only while an earlier one is still held downstream.
                if (!r_ovalid || !i_stall) begin
                    n_ovalid  = 1'b1;
                    n_vis_out = r_vis;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_phase  <= fbc_pkg::PH_COF;
            r_it     <= '0;
            r_s      <= '0;
            r_vis    <= 1'b0;
            r_inside <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_it     <= n_it;
            r_s      <= n_s;
            r_vis    <= n_vis;
            r_inside <= n_inside;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vis_out <= n_vis_out;
    end

    assign o_valid   = r_ovalid;
    assign o_visible = r_vis_out;

endmodule

// ----- src/fbc_alu.sv -----
`timescale 1ns / 1ps
// Shared saturating arithmetic unit: move, negate, add (also for a test), subtract and Q16.16 multiply.
// Depends on fbc_pkg for the operation codes.
module fbc_alu #(
    parameter int W = 32
) (
    input  logic [2:0]   i_op,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic [W-1:0] o_y
);

    localparam int QW = 2 * W - 16;
    localparam logic [W-1:0]  VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  VMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [QW-1:0] QLIM = QW'(VMAX);

    logic [W-1:0]   ma;
    logic [W-1:0]   mb;
    logic [2*W-1:0] prod;
    logic [QW-1:0]  q;
    logic           neg;
    logic [W:0]     sum;
    logic [W:0]     dif;
    logic [W-1:0]   mul_y;
    logic [W-1:0]   add_y;
    logic [W-1:0]   sub_y;
    logic [W-1:0]   neg_y;

    assign ma   = i_a[W-1] ? -i_a : i_a;
    assign mb   = i_b[W-1] ? -i_b : i_b;
    assign prod = (2*W)'(ma) * (2*W)'(mb);
    assign q    = prod[2*W-1:16];
    assign neg  = i_a[W-1] ^ i_b[W-1];

    always_comb begin
        if (q > QLIM) begin
            mul_y = neg ? VMIN : VMAX;
        end else begin
            mul_y = neg ? -q[W-1:0] : q[W-1:0];
        end
    end

    assign sum   = {i_a[W-1], i_a} + {i_b[W-1], i_b};
    assign dif   = {i_a[W-1], i_a} - {i_b[W-1], i_b};
    assign add_y = (sum[W] != sum[W-1]) ? (sum[W] ? VMIN : VMAX) : sum[W-1:0];
    assign sub_y = (dif[W] != dif[W-1]) ? (dif[W] ? VMIN : VMAX) : dif[W-1:0];
    assign neg_y = (i_a == VMIN) ? VMAX : -i_a;

    always_comb begin
        case (i_op)
            fbc_pkg::OP_NEG: o_y = neg_y;
            fbc_pkg::OP_ADD: o_y = add_y;
            fbc_pkg::OP_TST: o_y = add_y;
            fbc_pkg::OP_SUB: o_y = sub_y;
            fbc_pkg::OP_MUL: o_y = mul_y;
            default:         o_y = i_a;
        endcase
    end

endmodule

// ----- src/fbc_div.sv -----
`timescale 1ns / 1ps
// Iterative Q16.16 divider, one quotient bit per cycle, with saturation.
// Depends on nothing beyond its parameter.
module fbc_div #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic         o_done,
    output logic [W-1:0] o_q
);

    localparam int NW = W + 16;
    localparam int CW = $clog2(NW);
    localparam logic [W-1:0]  VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  VMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [NW-1:0] QLIM = NW'(VMAX);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_num;
    logic [NW-1:0] r_q;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_mb;
    logic          r_neg;
    logic          r_zero;
    logic [W-1:0]  r_zres;
    logic [W:0]    rem_sh;
    logic          ge;
    logic [W:0]    rem_sub;
    logic [W-1:0]  ma;

    assign ma      = i_a[W-1] ? -i_a : i_a;
    assign rem_sh  = {r_rem, r_num[NW-1]};
    assign ge      = rem_sh >= {1'b0, r_mb};
    assign rem_sub = rem_sh - {1'b0, r_mb};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= (i_b != '0);
                r_done <= (i_b == '0);
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= {ma, 16'b0};
            r_q    <= '0;
            r_rem  <= '0;
            r_mb   <= i_b[W-1] ? -i_b : i_b;
            r_neg  <= i_a[W-1] ^ i_b[W-1];
            r_cnt  <= CW'(NW - 1);
            r_zero <= (i_b == '0);
            if (i_a == '0) begin
                r_zres <= '0;
            end else begin
                r_zres <= i_a[W-1] ? VMIN : VMAX;
            end
        end else if (r_busy) begin
            r_num <= {r_num[NW-2:0], 1'b0};
            r_q   <= {r_q[NW-2:0], ge};
            r_rem <= ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
            r_cnt <= r_cnt - CW'(1);
        end
    end

    always_comb begin
        if (r_zero) begin
            o_q = r_zres;
        end else if (r_q > QLIM) begin
            o_q = r_neg ? VMIN : VMAX;
        end else begin
            o_q = r_neg ? -r_q[W-1:0] : r_q[W-1:0];
        end
    end

    assign o_done = r_done;

endmodule

// ----- src/fbc_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the frustum box culler, bound to the top level.
// Depends on the port list of frustum_box_culler_unit.
module fbc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic i_operation,
    input logic o_valid,
    input logic i_stall,
    input logic o_visible
);

    // A held result beat keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_visible))
        else $error("result beat changed while stalled");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat present after reset");

    // A box test keeps the block busy in the cycle after it is taken.
    a_box_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_operation |=> o_stall)
        else $error("box test did not occupy the block");

    // No result can be finished in the cycle right after an item is taken.
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> !$rose(o_valid))
        else $error("result appeared too early");

endmodule

bind frustum_box_culler_unit fbc_checker u_fbc_checker (.*);
